/* design/hsl2rgb_pkg.sv */
// Shared constants and types of the HSL to RGB color converter.
package hsl2rgb_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ONE = 1 << FRAC_BITS;
  localparam int HALF = ONE >> 1;
  localparam int VW = FRAC_BITS + 1;

  localparam int HW = 13;
  localparam int HUE_FULL = 5760;
  localparam int HUE_THIRD = 1920;
  localparam int HUE_SIXTH = 960;
  localparam int HUE_HALF = 2880;
  localparam int HUE_TWO_THIRDS = 3840;

  localparam int WW = 10;
  localparam int PW = VW + WW;
  localparam int DIV_SHIFT = 6;
  localparam int YW = PW - DIV_SHIFT;
  localparam int RECIP = 34953;
  localparam int RECIP_W = 17;
  localparam int RECIP_SHIFT = 19;

  localparam int CW = 8;
  localparam int NSTAGE = 6;

  localparam int IN_W = 64;
  localparam int OUT_W = 32;

  typedef logic [NSTAGE-1:0] stage_en_t;

  typedef struct packed {
    logic [VW-1:0] p;
    logic [VW-1:0] d;
    logic [WW-1:0] wr;
    logic [WW-1:0] wg;
    logic [WW-1:0] wb;
    logic [VW-1:0] a;
  } mix_t;

endpackage

/* design/hsl2rgb_front.sv */
// Front stages: input clamp, hue offsets, lightness-saturation product, hue weights and p/q.
module hsl2rgb_front (
  input  logic                      clk,
  input  logic [2:0]                en,
  input  logic signed [15:0]        hue,
  input  logic signed [13:0]        saturation,
  input  logic signed [13:0]        lightness,
  input  logic signed [13:0]        opacity,
  output hsl2rgb_pkg::mix_t         mix
);
  import hsl2rgb_pkg::*;

  function automatic logic [VW-1:0] clamp_frac(input logic signed [13:0] x);
    logic [VW-1:0] r;
    if (x[13]) begin
      r = '0;
    end else if (x[12:0] > 13'(ONE)) begin
      r = VW'(ONE);
    end else begin
      r = VW'(x[12:0]);
    end
    return r;
  endfunction

  function automatic logic [WW-1:0] weight(input logic [HW-1:0] t);
    logic [WW-1:0] r;
    if (t < HW'(HUE_SIXTH)) begin
      r = WW'(t);
    end else if (t < HW'(HUE_HALF)) begin
      r = WW'(HUE_SIXTH);
    end else if (t < HW'(HUE_TWO_THIRDS)) begin
      r = WW'(HW'(HUE_TWO_THIRDS) - t);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  logic [HW-1:0] h_c;
  logic [HW-1:0] tr_c;
  logic [HW-1:0] tb_c;

  logic [HW-1:0] tr1;
  logic [HW-1:0] tg1;
  logic [HW-1:0] tb1;
  logic [VW-1:0] s1;
  logic [VW-1:0] l1;
  logic [VW-1:0] a1;

  logic [2*VW-1:0] prod2;
  logic [VW-1:0]   s2;
  logic [VW-1:0]   l2;
  logic [VW-1:0]   a2;
  logic [WW-1:0]   wr2;
  logic [WW-1:0]   wg2;
  logic [WW-1:0]   wb2;

  logic [VW-1:0] ls3;
  logic [VW:0]   q3;
  logic [VW:0]   p3;

  always_comb begin
    if (hue[15]) begin
      h_c = '0;
    end else if (hue[14:0] > 15'(HUE_FULL)) begin
      h_c = HW'(HUE_FULL);
    end else begin
      h_c = HW'(hue[14:0]);
    end
    if (h_c > HW'(HUE_TWO_THIRDS)) begin
      tr_c = h_c - HW'(HUE_TWO_THIRDS);
    end else begin
      tr_c = h_c + HW'(HUE_THIRD);
    end
    if (h_c < HW'(HUE_THIRD)) begin
      tb_c = h_c + HW'(HUE_TWO_THIRDS);
    end else begin
      tb_c = h_c - HW'(HUE_THIRD);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tr1 <= tr_c;
      tg1 <= h_c;
      tb1 <= tb_c;
      s1  <= clamp_frac(saturation);
      l1  <= clamp_frac(lightness);
      a1  <= clamp_frac(opacity);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod2 <= (2*VW)'(l1) * (2*VW)'(s1);
      s2    <= s1;
      l2    <= l1;
      a2    <= a1;
      wr2   <= weight(tr1);
      wg2   <= weight(tg1);
      wb2   <= weight(tb1);
    end
  end

  always_comb begin
    ls3 = VW'(prod2 >> FRAC_BITS);
    if (l2 < VW'(HALF)) begin
      q3 = (VW+1)'(l2) + (VW+1)'(ls3);
    end else begin
      q3 = (VW+1)'(l2) + (VW+1)'(s2) - (VW+1)'(ls3);
    end
    p3 = {l2, 1'b0} - q3;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mix.p  <= VW'(p3);
      mix.d  <= VW'(q3 - p3);
      mix.wr <= wr2;
      mix.wg <= wg2;
      mix.wb <= wb2;
      mix.a  <= a2;
    end
  end

endmodule

/* design/hsl2rgb_chan.sv */
// Back stages of one channel: ramp product, divide by 960, scale to eight bits.
module hsl2rgb_chan (
  input  logic                         clk,
  input  logic [2:0]                   en,
  input  logic [hsl2rgb_pkg::VW-1:0]   p,
  input  logic [hsl2rgb_pkg::VW-1:0]   d,
  input  logic [hsl2rgb_pkg::WW-1:0]   w,
  output logic [hsl2rgb_pkg::CW-1:0]   value
);
  import hsl2rgb_pkg::*;

  logic [PW-1:0] prod4;
  logic [VW-1:0] p4;

  logic [YW+RECIP_W-1:0] scaled;
  logic [VW-1:0] quo5;
  logic [VW-1:0] p5;

  logic [VW-1:0]   v6;
  logic [VW+7:0]   v255;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod4 <= PW'(d) * PW'(w);
      p4    <= p;
    end
  end

  assign scaled = (YW+RECIP_W)'(prod4 >> DIV_SHIFT) * (YW+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      quo5 <= VW'(scaled >> RECIP_SHIFT);
      p5   <= p4;
    end
  end

  always_comb begin
    v6   = p5 + quo5;
    v255 = {v6, 8'd0} - (VW+8)'(v6);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      value <= CW'(v255 >> FRAC_BITS);
    end
  end

endmodule

/* design/hsl_to_rgb_converter_core.sv */
// Top level of the HSL to RGB color converter with stream handshake and stage control.
//
// Use: each item on the slave stream carries one HSL pixel with opacity in
// s_axis_tdata; one item with eight-bit red, green, blue and alpha leaves on
// the master stream for every item taken, in the same order.
// Out-of-range inputs are clamped, so every bit pattern gives a defined color.
// The pipeline has six register stages: clamp, product, p/q, ramp product,
// divide by 960 and byte scaling, the last one being the output register.
// The first stage is loaded at the edge that accepts an item; the item then
// moves through the stages in order and m_axis_tvalid rises once it reaches
// the output register. Throughput is one item per cycle while the receiver
// is ready; each stage takes a new item whenever it is empty or its content
// moves on, so bubbles are squeezed out.
// When the receiver stalls, the output holds its item and the pipeline keeps
// accepting until all six stages are full, then s_axis_tready goes low.
// Reset clears all stage valid bits; the data registers are not reset.
module hsl_to_rgb_converter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // hue[15:0], saturation[29:16], lightness[43:30], opacity[57:44], zero fill
  input  logic [hsl2rgb_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // red[7:0], green[15:8], blue[23:16], alpha_out[31:24]
  output logic [hsl2rgb_pkg::OUT_W-1:0]  m_axis_tdata
);
  import hsl2rgb_pkg::*;

  stage_en_t vld;
  stage_en_t en;
  mix_t      mix;

  logic [CW-1:0] red;
  logic [CW-1:0] green;
  logic [CW-1:0] blue;
  logic [CW-1:0] alpha_out;

  always_comb begin
    en[NSTAGE-1] = ~vld[NSTAGE-1] | m_axis_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = ~vld[i] | en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  hsl2rgb_front u_front (
    .clk        (clk),
    .en         (en[2:0]),
    .hue        (s_axis_tdata[15:0]),
    .saturation (s_axis_tdata[29:16]),
    .lightness  (s_axis_tdata[43:30]),
    .opacity    (s_axis_tdata[57:44]),
    .mix        (mix)
  );

  hsl2rgb_chan u_red (
    .clk   (clk),
    .en    (en[5:3]),
    .p     (mix.p),
    .d     (mix.d),
    .w     (mix.wr),
    .value (red)
  );

  hsl2rgb_chan u_green (
    .clk   (clk),
    .en    (en[5:3]),
    .p     (mix.p),
    .d     (mix.d),
    .w     (mix.wg),
    .value (green)
  );

  hsl2rgb_chan u_blue (
    .clk   (clk),
    .en    (en[5:3]),
    .p     (mix.p),
    .d     (mix.d),
    .w     (mix.wb),
    .value (blue)
  );

  hsl2rgb_chan u_alpha (
    .clk   (clk),
    .en    (en[5:3]),
    .p     (mix.a),
    .d     ('0),
    .w     ('0),
    .value (alpha_out)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[NSTAGE-1];
  assign m_axis_tdata  = {alpha_out, blue, green, red};

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled although the output side is ready");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_first_stage_holds: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !en[0] |=> vld[0])
    else $error("item in the first stage lost during a stall");

endmodule
